// ----- sv/fifo_quantity_order_matcher_defines.svh -----
// assertion macros used by the checker file
`ifndef FIFO_QUANTITY_ORDER_MATCHER_DEFINES_SVH
`define FIFO_QUANTITY_ORDER_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off while reset is high
`define FQOM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising edge, off while reset is high
`define FQOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/fqom_pkg.sv -----
`default_nettype none

package fqom_pkg;

   localparam int QTY_W    = 16;
   localparam int TRADER_W = 8;
   localparam int STOCK_W  = 16;

   // one resting order as held in a book
   typedef struct packed {
      logic [QTY_W-1:0]    qty;
      logic [TRADER_W-1:0] trader;
      logic [STOCK_W-1:0]  stock;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      EV_RESTING_FILLED  = 2'd0,
      EV_INCOMING_FILLED = 2'd1,
      EV_INCOMING_RESTED = 2'd2,
      EV_DROPPED_FULL    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CONSUME,
      ST_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic rd_issue;
      logic consume_full;
      logic consume_part;
      logic emit_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic want_zero;
      logic opp_empty;
      logic part_fill;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/fqom_ram.sv -----
`default_nettype none

module fqom_ram #(
   parameter int WIDTH  = 40,
   parameter int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/fqom_ctrl.sv -----
`default_nettype none

module fqom_ctrl import fqom_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.want_zero || status.opp_empty) begin
               state_in = ST_FINAL;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_CONSUME;
            end
         end
         ST_CONSUME: begin
            // partial fill of the head entry ends the walk without a report
            if (status.part_fill) begin
               cmd.consume_part = 1'b1;
               state_in         = ST_FINAL;
            end else if (status.out_free) begin
               cmd.consume_full = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/fqom_datapath.sv -----
`default_nettype none

module fqom_datapath import fqom_pkg::*; #(
   parameter int BOOK_DEPTH = 32,
   localparam int IDX_W = $clog2(BOOK_DEPTH),
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                req_is_buy,
   input  wire logic [QTY_W-1:0]    req_order_quantity,
   input  wire logic [TRADER_W-1:0] req_trader_id,
   input  wire logic [STOCK_W-1:0]  req_stock_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_event_kind,
   output logic [TRADER_W-1:0]      rsp_report_trader,
   output logic [STOCK_W-1:0]       rsp_report_stock,
   output logic [QTY_W-1:0]         rsp_rest_quantity,
   output logic                     rsp_last_event
);

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BOOK_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(BOOK_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_WIDE = (CNT_W + 1)'(BOOK_DEPTH);

   // incoming order being worked
   logic                is_buy_ff, is_buy_in;
   logic [QTY_W-1:0]    want_ff, want_in;
   logic [TRADER_W-1:0] trader_ff, trader_in;
   logic [STOCK_W-1:0]  stock_ff, stock_in;

   // ring pointers of both books
   logic [IDX_W-1:0] buy_head_ff, buy_head_in, sell_head_ff, sell_head_in;
   logic [CNT_W-1:0] buy_count_ff, buy_count_in, sell_count_ff, sell_count_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   event_type           rsp_kind_ff, rsp_kind_in;
   logic [TRADER_W-1:0] rsp_trader_ff, rsp_trader_in;
   logic [STOCK_W-1:0]  rsp_stock_ff, rsp_stock_in;
   logic [QTY_W-1:0]    rsp_rest_ff, rsp_rest_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [ENTRY_W-1:0] buy_rd_data, sell_rd_data;
   logic [ENTRY_W-1:0] buy_wr_data, sell_wr_data;
   logic [IDX_W-1:0]   buy_wr_addr, sell_wr_addr;
   logic               buy_wr_en, sell_wr_en;

   entry_type        opp_entry, part_entry, new_entry;
   logic [IDX_W-1:0] opp_head, own_head, opp_head_next, tail_idx;
   logic [CNT_W-1:0] opp_count, own_count;
   logic [CNT_W:0]   tail_sum;
   logic             own_full, rest_write, out_load;
   event_type        final_kind;

   assign opp_head  = is_buy_ff ? sell_head_ff  : buy_head_ff;
   assign opp_count = is_buy_ff ? sell_count_ff : buy_count_ff;
   assign own_head  = is_buy_ff ? buy_head_ff   : sell_head_ff;
   assign own_count = is_buy_ff ? buy_count_ff  : sell_count_ff;
   assign opp_entry = entry_type'(is_buy_ff ? sell_rd_data : buy_rd_data);

   assign opp_head_next = (opp_head == LAST_IDX) ? '0 : opp_head + 1'b1;

   // head below depth and count at most depth, so one subtract wraps it
   assign tail_sum = (CNT_W + 1)'(own_head) + (CNT_W + 1)'(own_count);
   assign tail_idx = (tail_sum >= DEPTH_WIDE) ? IDX_W'(tail_sum - DEPTH_WIDE)
                                              : IDX_W'(tail_sum);

   assign own_full = (own_count == FULL_CNT);

   assign status.want_zero = (want_ff == '0);
   assign status.opp_empty = (opp_count == '0);
   assign status.part_fill = (want_ff < opp_entry.qty);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign final_kind = status.want_zero ? EV_INCOMING_FILLED :
                       own_full         ? EV_DROPPED_FULL    : EV_INCOMING_RESTED;

   assign rest_write = cmd.emit_final && !status.want_zero && !own_full;
   assign out_load   = cmd.consume_full || cmd.emit_final;

   always_comb begin
      part_entry     = opp_entry;
      part_entry.qty = opp_entry.qty - want_ff;
      new_entry.qty    = want_ff;
      new_entry.trader = trader_ff;
      new_entry.stock  = stock_ff;
   end

   // book writes: partial fill on the opposite side, rest on the own side
   assign buy_wr_en    = (cmd.consume_part && !is_buy_ff) || (rest_write && is_buy_ff);
   assign buy_wr_addr  = is_buy_ff ? tail_idx : buy_head_ff;
   assign buy_wr_data  = is_buy_ff ? new_entry : part_entry;
   assign sell_wr_en   = (cmd.consume_part && is_buy_ff) || (rest_write && !is_buy_ff);
   assign sell_wr_addr = is_buy_ff ? sell_head_ff : tail_idx;
   assign sell_wr_data = is_buy_ff ? part_entry : new_entry;

   fqom_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BOOK_DEPTH)
   ) u_buy_book (
      .clock   (clock),
      .wr_en   (buy_wr_en),
      .wr_addr (buy_wr_addr),
      .wr_data (buy_wr_data),
      .rd_en   (cmd.rd_issue && !is_buy_ff),
      .rd_addr (buy_head_ff),
      .rd_data (buy_rd_data)
   );

   fqom_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BOOK_DEPTH)
   ) u_sell_book (
      .clock   (clock),
      .wr_en   (sell_wr_en),
      .wr_addr (sell_wr_addr),
      .wr_data (sell_wr_data),
      .rd_en   (cmd.rd_issue && is_buy_ff),
      .rd_addr (sell_head_ff),
      .rd_data (sell_rd_data)
   );

   always_comb begin
      is_buy_in     = is_buy_ff;
      want_in       = want_ff;
      trader_in     = trader_ff;
      stock_in      = stock_ff;
      buy_head_in   = buy_head_ff;
      buy_count_in  = buy_count_ff;
      sell_head_in  = sell_head_ff;
      sell_count_in = sell_count_ff;

      if (cmd.load_req) begin
         is_buy_in = req_is_buy;
         want_in   = req_order_quantity;
         trader_in = req_trader_id;
         stock_in  = req_stock_id;
      end

      if (cmd.consume_full) begin
         want_in = want_ff - opp_entry.qty;
         if (is_buy_ff) begin
            sell_head_in  = opp_head_next;
            sell_count_in = sell_count_ff - 1'b1;
         end else begin
            buy_head_in  = opp_head_next;
            buy_count_in = buy_count_ff - 1'b1;
         end
      end

      if (cmd.consume_part) begin
         want_in = '0;
      end

      if (rest_write) begin
         if (is_buy_ff) begin
            buy_count_in = buy_count_ff + 1'b1;
         end else begin
            sell_count_in = sell_count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_kind_in   = rsp_kind_ff;
      rsp_trader_in = rsp_trader_ff;
      rsp_stock_in  = rsp_stock_ff;
      rsp_rest_in   = rsp_rest_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_final;
         if (cmd.consume_full) begin
            rsp_kind_in   = EV_RESTING_FILLED;
            rsp_trader_in = opp_entry.trader;
            rsp_stock_in  = opp_entry.stock;
            rsp_rest_in   = '0;
         end else begin
            rsp_kind_in   = final_kind;
            rsp_trader_in = trader_ff;
            rsp_stock_in  = stock_ff;
            rsp_rest_in   = want_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buy_head_ff   <= '0;
         buy_count_ff  <= '0;
         sell_head_ff  <= '0;
         sell_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         buy_head_ff   <= buy_head_in;
         buy_count_ff  <= buy_count_in;
         sell_head_ff  <= sell_head_in;
         sell_count_ff <= sell_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_buy_ff     <= is_buy_in;
      want_ff       <= want_in;
      trader_ff     <= trader_in;
      stock_ff      <= stock_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_trader_ff <= rsp_trader_in;
      rsp_stock_ff  <= rsp_stock_in;
      rsp_rest_ff   <= rsp_rest_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_report_trader = rsp_trader_ff;
   assign rsp_report_stock  = rsp_stock_ff;
   assign rsp_rest_quantity = rsp_rest_ff;
   assign rsp_last_event    = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sv/fifo_quantity_order_matcher.sv -----
// channel  direction  handshake          payload
// req      in         req_valid/stall    is_buy, order_quantity, trader_id, stock_id
// rsp      out        rsp_valid/stall    event_kind, report_trader, report_stock,
//                                        rest_quantity, last_event
//
// one order at a time: the sequencer takes it, looks at the opposite book head,
// does a registered read of each resting entry it consumes and looks again, then
// emits the final transaction; a partial fill goes straight to the final transaction
// synchronous active-high reset clears both ring pointers and the result valid
// flag; book contents are not cleared, only counted entries are read
// a stalled rsp holds its transaction and the walk waits for it
`default_nettype none

module fifo_quantity_order_matcher import fqom_pkg::*; #(
   parameter int BOOK_DEPTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_is_buy,
   input  wire logic [QTY_W-1:0]    req_order_quantity,
   input  wire logic [TRADER_W-1:0] req_trader_id,
   input  wire logic [STOCK_W-1:0]  req_stock_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_event_kind,
   output logic [TRADER_W-1:0]      rsp_report_trader,
   output logic [STOCK_W-1:0]       rsp_report_stock,
   output logic [QTY_W-1:0]         rsp_rest_quantity,
   output logic                     rsp_last_event
);

   // commands from the sequencer, status back from the books
   cmd_type    cmd;
   status_type status;

   // sequencer: take order, walk opposite book head, close with a final event
   fqom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // both books, their ring pointers, the working order and the result register
   fqom_datapath #(
      .BOOK_DEPTH (BOOK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_is_buy         (req_is_buy),
      .req_order_quantity (req_order_quantity),
      .req_trader_id      (req_trader_id),
      .req_stock_id       (req_stock_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_report_trader  (rsp_report_trader),
      .rsp_report_stock   (rsp_report_stock),
      .rsp_rest_quantity  (rsp_rest_quantity),
      .rsp_last_event     (rsp_last_event)
   );

endmodule

`default_nettype wire

// ----- sv/fqom_checker.sv -----
`default_nettype none
`include "fifo_quantity_order_matcher_defines.svh"

module fqom_checker import fqom_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [1:0]          rsp_event_kind,
   input wire logic [TRADER_W-1:0] rsp_report_trader,
   input wire logic [STOCK_W-1:0]  rsp_report_stock,
   input wire logic [QTY_W-1:0]    rsp_rest_quantity,
   input wire logic                rsp_last_event
);

   // stalled transaction holds
   `FQOM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_report_trader) && $stable(rsp_report_stock) && $stable(rsp_rest_quantity) && $stable(rsp_last_event), "rsp transaction changed under stall")

   // one order in flight at a time
   `FQOM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "second order taken while one is in flight")

   // resting fills never close an order and carry no rest
   `FQOM_ASSERT_NOW(a_resting_not_last, clock, reset, rsp_valid && (rsp_event_kind == EV_RESTING_FILLED), !rsp_last_event && (rsp_rest_quantity == '0), "resting fill marked final or with rest")

   // every other kind closes the order
   `FQOM_ASSERT_NOW(a_final_is_last, clock, reset, rsp_valid && (rsp_event_kind != EV_RESTING_FILLED), rsp_last_event, "final event without last flag")

   // an incoming fill leaves nothing over
   `FQOM_ASSERT_NOW(a_filled_no_rest, clock, reset, rsp_valid && (rsp_event_kind == EV_INCOMING_FILLED), rsp_rest_quantity == '0, "incoming fill with rest quantity")

endmodule

bind fifo_quantity_order_matcher fqom_checker u_fqom_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_kind    (rsp_event_kind),
   .rsp_report_trader (rsp_report_trader),
   .rsp_report_stock  (rsp_report_stock),
   .rsp_rest_quantity (rsp_rest_quantity),
   .rsp_last_event    (rsp_last_event)
);

`default_nettype wire

// ----- sim/tb_fifo_quantity_order_matcher.sv -----
`timescale 1ns / 1ps

module tb_fifo_quantity_order_matcher import fqom_pkg::*; ();

   localparam int BOOK_DEPTH  = 32;
   // worst order: one look per entry plus one read per entry, then the final
   localparam int DRAIN_WAIT  = 3 + 2 * (BOOK_DEPTH + 1) + 40;
   localparam int HOLD_CYCLES = 300;

   // one expected result transaction
   typedef struct packed {
      event_type           kind;
      logic [TRADER_W-1:0] trader;
      logic [STOCK_W-1:0]  stock;
      logic [QTY_W-1:0]    rest;
      logic                last;
   } fill_event_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_is_buy;
   logic [QTY_W-1:0]    req_order_quantity;
   logic [TRADER_W-1:0] req_trader_id;
   logic [STOCK_W-1:0]  req_stock_id;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_event_kind;
   logic [TRADER_W-1:0] rsp_report_trader;
   logic [STOCK_W-1:0]  rsp_report_stock;
   logic [QTY_W-1:0]    rsp_rest_quantity;
   logic                rsp_last_event;

   // shadow copies of both books, oldest order at the front
   entry_type      resting_buys[$];
   entry_type      resting_sells[$];
   // events still owed by the block, oldest first
   fill_event_type pending_events[$];

   int mismatch_count = 0;
   int send_idle_max  = 9;
   int rsp_idle_max   = 9;
   bit hold_trigger   = 1'b0;

   fifo_quantity_order_matcher #(
      .BOOK_DEPTH(BOOK_DEPTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_is_buy         (req_is_buy),
      .req_order_quantity (req_order_quantity),
      .req_trader_id      (req_trader_id),
      .req_stock_id       (req_stock_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_report_trader  (rsp_report_trader),
      .rsp_report_stock   (rsp_report_stock),
      .rsp_rest_quantity  (rsp_rest_quantity),
      .rsp_last_event     (rsp_last_event)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

   // match one incoming order against the shadow books and queue its events
   function automatic void predict_order(input logic buy, input logic [QTY_W-1:0] qty,
                                         input logic [TRADER_W-1:0] trader,
                                         input logic [STOCK_W-1:0] stock);
      entry_type      opposite[$];
      entry_type      own[$];
      entry_type      head;
      logic [QTY_W-1:0] want;
      fill_event_type ev;
      want = qty;
      if (buy) begin
         opposite = resting_sells;
         own      = resting_buys;
      end else begin
         opposite = resting_buys;
         own      = resting_sells;
      end
      // walk the opposite book from its oldest order, price and stock ignored
      while (want != 0 && opposite.size() != 0) begin
         head = opposite[0];
         if (want < head.qty) begin
            // partial consumption keeps its place and is not reported
            head.qty    = head.qty - want;
            opposite[0] = head;
            want        = '0;
         end else begin
            want = want - head.qty;
            ev   = '{EV_RESTING_FILLED, head.trader, head.stock, '0, 1'b0};
            pending_events = {pending_events, ev};
            opposite.delete(0);
         end
      end
      if (want == 0) begin
         ev = '{EV_INCOMING_FILLED, trader, stock, '0, 1'b1};
      end else if (own.size() >= BOOK_DEPTH) begin
         // own book full, remainder is lost
         ev = '{EV_DROPPED_FULL, trader, stock, want, 1'b1};
      end else begin
         head.qty    = want;
         head.trader = trader;
         head.stock  = stock;
         own         = {own, head};
         ev = '{EV_INCOMING_RESTED, trader, stock, want, 1'b1};
      end
      pending_events = {pending_events, ev};
      if (buy) begin
         resting_sells = opposite;
         resting_buys  = own;
      end else begin
         resting_buys  = opposite;
         resting_sells = own;
      end
   endfunction

   // offer one order after a random gap, hold it until taken, then predict
   task automatic place_order(input logic buy, input logic [QTY_W-1:0] qty,
                              input logic [TRADER_W-1:0] trader,
                              input logic [STOCK_W-1:0] stock);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_is_buy         <= buy;
      req_order_quantity <= qty;
      req_trader_id      <= trader;
      req_stock_id       <= stock;
      do @(posedge clock); while (req_stall);
      predict_order(buy, qty, trader, stock);
   endtask

   task automatic place_random_order(input logic buy, input int qty_max);
      place_order(buy, QTY_W'($urandom_range(1, qty_max)),
                  TRADER_W'($urandom_range(0, 255)), STOCK_W'($urandom_range(0, 65535)));
   endtask

   // result side stall: a fresh wait after each transaction, plus long hold-offs
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_left    = HOLD_CYCLES;
            hold_trigger = 1'b0;
         end
         if (!reset && rsp_valid && !rsp_stall)
            stall_left = $urandom_range(0, rsp_idle_max);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare every accepted result transaction with the oldest expected event
   always @(posedge clock) begin
      fill_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result transaction: kind %0d trader %0d stock %0d",
                   rsp_event_kind, rsp_report_trader, rsp_report_stock);
            mismatch_count++;
         end else begin
            want = pending_events[0];
            pending_events.delete(0);
            if (rsp_event_kind !== want.kind) begin
               $error("event_kind: expected %0d, actual %0d", want.kind, rsp_event_kind);
               mismatch_count++;
            end
            if (rsp_report_trader !== want.trader) begin
               $error("report_trader: expected %0d, actual %0d", want.trader,
                      rsp_report_trader);
               mismatch_count++;
            end
            if (rsp_report_stock !== want.stock) begin
               $error("report_stock: expected %0d, actual %0d", want.stock,
                      rsp_report_stock);
               mismatch_count++;
            end
            if (rsp_rest_quantity !== want.rest) begin
               $error("rest_quantity: expected %0d, actual %0d", want.rest,
                      rsp_rest_quantity);
               mismatch_count++;
            end
            if (rsp_last_event !== want.last) begin
               $error("last_event: expected %0d, actual %0d", want.last, rsp_last_event);
               mismatch_count++;
            end
         end
      end
   end

   // hand-picked orders: zero quantity, field extremes, partial and exact fills
   task automatic test_matching_basics();
      place_order(1'b0, 16'd0, 8'h00, 16'h0000);     // zero quantity on empty books
      place_order(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);  // largest buy rests
      place_order(1'b0, 16'd1, 8'h55, 16'hAAAA);     // nibbles the resting buy
      place_order(1'b0, 16'hFFFF, 8'hAA, 16'h5555);  // clears it, remainder rests
      place_order(1'b1, 16'd0, 8'h01, 16'h0001);     // zero quantity, book not empty
      place_order(1'b1, 16'd1, 8'h02, 16'h0002);     // exact fill of the rest
      place_order(1'b1, 16'd10, 8'h11, 16'h1000);
      place_order(1'b1, 16'd20, 8'h12, 16'h2000);
      place_order(1'b1, 16'd30, 8'h13, 16'h3000);
      place_order(1'b0, 16'd35, 8'h21, 16'h0100);    // two full, one partial
      place_order(1'b0, 16'd25, 8'h22, 16'h0200);    // exact fill of reduced head
      place_order(1'b0, 16'd40, 8'h23, 16'h0300);
      place_order(1'b1, 16'd15, 8'h31, 16'h0400);
      place_order(1'b1, 16'd25, 8'h32, 16'h0500);
      place_order(1'b1, 16'd7, 8'h33, 16'h0600);
      place_order(1'b0, 16'd8, 8'h34, 16'h0700);
   endtask

   // fill the sell book to the brim, overflow it, sweep it at once, then fill and overflow the buy book
   task automatic test_book_overflow();
      while (resting_sells.size() < BOOK_DEPTH)
         place_random_order(1'b0, 100);
      repeat (2) place_random_order(1'b0, 100);
      // one large buy takes every resting sell, the most events an order can make
      place_order(1'b1, 16'hFFFF, TRADER_W'($urandom_range(0, 255)),
                  STOCK_W'($urandom_range(0, 65535)));
      while (resting_buys.size() < BOOK_DEPTH)
         place_random_order(1'b1, 100);
      repeat (2) place_random_order(1'b1, 100);
   endtask

   // long result hold-off while orders keep coming, so the input backs up
   task automatic test_result_hold_off();
      hold_trigger = 1'b1;
      repeat (10) place_random_order(1'($urandom_range(0, 1)), 60);
   endtask

   task automatic test_random_orders(input int count);
      int pick;
      logic [QTY_W-1:0] qty;
      for (int i = 0; i < count; i++) begin
         // a stretch with no idling on either side
         if (i == count / 3) begin
            send_idle_max = 0;
            rsp_idle_max  = 0;
         end
         if (i == 2 * count / 3) begin
            send_idle_max = 9;
            rsp_idle_max  = 9;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)
            qty = '0;
         else if (pick == 1)
            qty = QTY_W'($urandom_range(0, 65535));
         else
            qty = QTY_W'($urandom_range(1, 40));
         place_order(1'($urandom_range(0, 1)), qty, TRADER_W'($urandom_range(0, 255)),
                     STOCK_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_is_buy         <= 1'b0;
      req_order_quantity <= '0;
      req_trader_id      <= '0;
      req_stock_id       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_matching_basics();
      test_book_overflow();
      test_result_hold_off();
      test_random_orders(24);

      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      // let any stray transaction show itself
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fqom_pkg.sv
sv/fqom_ram.sv
sv/fqom_ctrl.sv
sv/fqom_datapath.sv
sv/fifo_quantity_order_matcher.sv
sv/fqom_checker.sv
sim/tb_fifo_quantity_order_matcher.sv
